### sv/bit_packer_emulation_prevention_top_macros.svh
// Assertion macros shared by the bit packer RTL.
`ifndef BIT_PACKER_EMULATION_PREVENTION_TOP_MACROS_SVH
`define BIT_PACKER_EMULATION_PREVENTION_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bpep_pkg.sv
// Types and constants shared by the bit packer with emulation prevention.
`default_nettype none

package bpep_pkg;

  // Input transaction: the low bit_count bits of code_word are written MSB first.
  typedef struct packed {
    logic [31:0] code_word;
    logic [5:0]  bit_count;
  } in_t;

  // Output transaction: one stored byte, or an empty marker when no byte completed.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       is_inserted;
    logic       full_error;
    logic       last;
  } out_t;

  // Result of one merge step of the shared shift unit.
  typedef struct packed {
    logic       byte_done;
    logic [7:0] bits;
    logic [2:0] count;
    logic [5:0] rem;
  } merge_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_GATHER,
    S_INSERT,
    S_DATA,
    S_EMPTY
  } state_e;

  // Configuration register indexes.
  localparam logic CfgCapacity = 1'b0;
  localparam logic CfgPrevent  = 1'b1;

  // Byte constants.
  localparam logic [7:0] EpbByte  = 8'h03;
  localparam logic [7:0] EpbMask  = 8'hFC;
  localparam logic [7:0] ZeroByte = 8'h00;

  // Write width limits; a write of exactly NoPreventWidth bits skips prevention.
  localparam logic [5:0] MaxWriteBits   = 6'd32;
  localparam logic [5:0] NoPreventWidth = 6'd32;
  localparam logic [3:0] ByteBits       = 4'd8;

  // Reset values of the configuration registers.
  localparam logic [20:0] CapacityReset = 21'd1048576;
  localparam logic        PreventReset  = 1'b1;

  // Zero-run counter saturates at two.
  localparam logic [1:0] ZeroRunMax = 2'd2;

endpackage

`default_nettype wire

### sv/bpep_merge.sv
// Shared shift unit: moves the next slice of a code word into the pending byte.
`default_nettype none

module bpep_merge (
  input  logic [31:0]          code_i,
  input  logic [5:0]           rem_i,
  input  logic [7:0]           pend_bits_i,
  input  logic [2:0]           pend_cnt_i,
  output bpep_pkg::merge_t     merge_o
);

  logic [3:0]  space;
  logic [3:0]  take;
  logic [5:0]  shamt;
  logic [31:0] shifted;
  logic [7:0]  mask;
  logic [7:0]  chunk;
  logic [15:0] merged;

  // Take as many bits as fit into the pending byte, or all that remain.
  always_comb begin
    space   = bpep_pkg::ByteBits - {1'b0, pend_cnt_i};
    take    = ({2'b0, space} <= rem_i) ? space : rem_i[3:0];
    shamt   = rem_i - {2'b0, take};
    shifted = code_i >> shamt;
    mask    = 8'((9'd1 << take) - 9'd1);
    chunk   = shifted[7:0] & mask;
    merged  = ({8'b0, pend_bits_i} << take) | {8'b0, chunk};
  end

  // A byte completes when the slice fills all free positions.
  always_comb begin
    merge_o.byte_done = (take == space);
    merge_o.bits      = merged[7:0];
    merge_o.count     = merge_o.byte_done ? 3'd0 : (pend_cnt_i + take[2:0]);
    merge_o.rem       = shamt;
  end

endmodule

`default_nettype wire

### sv/bit_packer_emulation_prevention_top.sv
// Top level of the bit packer with H.264 emulation prevention.
`default_nettype none

`include "bit_packer_emulation_prevention_top_macros.svh"

// Packs the low bit_count bits of each code word, MSB first, into bytes and
// emits every completed byte as one output transaction, preceded by an
// inserted 0x03 when prevention is on, the write is narrower than 32 bits,
// the two bytes stored last are zero and the new byte is 0x03 or less. A
// write that completes no byte yields one transaction with byte_valid low.
// The last output of each write carries last. Once the stored byte count
// reaches capacity_bytes, full_error stays set and later bits are dropped.
// Sequence: a write is accepted in S_IDLE, the shift unit completes each
// byte in S_GATHER and a final S_GATHER pass keeps the leftover bits, and
// each stored byte, an inserted one included, is issued from S_INSERT or
// S_DATA, or S_EMPTY issues the empty transaction. A write that fills the
// buffer skips the final shift-unit pass. A single shared shift-and-merge
// unit and the single output register carry every write, and the output
// register stalls the sequencer while the consumer holds ready low. The
// input is ready only between writes. No clearing pass is needed after
// reset.
module bit_packer_emulation_prevention_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input channel.
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bpep_pkg::in_t    in_data_i,
  // Output channel.
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bpep_pkg::out_t   out_data_o,
  // Configuration write port.
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [20:0]      cfg_data_i
);

  bpep_pkg::state_e state_q, state_d;

  logic [20:0] cap_q;
  logic        prev_en_q;
  logic [31:0] code_q, code_d;
  logic [5:0]  rem_q, rem_d;
  logic        prevent_q, prevent_d;
  logic        emitted_q, emitted_d;
  logic [7:0]  pend_bits_q, pend_bits_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic [7:0]  byte_q, byte_d;
  logic [1:0]  zero_run_q, zero_run_d;
  logic [20:0] stored_q, stored_d;
  logic        full_q, full_d;
  logic        out_valid_q, out_valid_d;
  bpep_pkg::out_t out_q, out_d;

  bpep_pkg::merge_t merge;
  logic        accept;
  logic        out_free;
  logic        ins_cond;
  logic [5:0]  n_clamped;
  logic [7:0]  store_val;
  logic [20:0] stored_inc;
  logic        full_new;
  logic [1:0]  zero_run_new;

  // Shared shift-and-merge unit.
  bpep_merge u_merge (
    .code_i      (code_q),
    .rem_i       (rem_q),
    .pend_bits_i (pend_bits_q),
    .pend_cnt_i  (pend_cnt_q),
    .merge_o     (merge)
  );

  // Handshake and shared byte-store arithmetic.
  always_comb begin
    accept       = in_valid_i && in_ready_o;
    out_free     = !out_valid_q || out_ready_i;
    n_clamped    = (in_data_i.bit_count > bpep_pkg::MaxWriteBits) ?
                   bpep_pkg::MaxWriteBits : in_data_i.bit_count;
    ins_cond     = prevent_q && (zero_run_q == bpep_pkg::ZeroRunMax) &&
                   ((merge.bits & bpep_pkg::EpbMask) == bpep_pkg::ZeroByte);
    store_val    = (state_q == bpep_pkg::S_INSERT) ? bpep_pkg::EpbByte : byte_q;
    stored_inc   = stored_q + 21'd1;
    full_new     = full_q || (stored_inc >= cap_q);
    if (store_val == bpep_pkg::ZeroByte) begin
      zero_run_new = (zero_run_q == bpep_pkg::ZeroRunMax) ? zero_run_q : zero_run_q + 2'd1;
    end else begin
      zero_run_new = 2'd0;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpep_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bpep_pkg::S_GATHER;
      end
      bpep_pkg::S_GATHER: begin
        if (merge.byte_done) begin
          state_d = ins_cond ? bpep_pkg::S_INSERT : bpep_pkg::S_DATA;
        end else begin
          state_d = emitted_q ? bpep_pkg::S_IDLE : bpep_pkg::S_EMPTY;
        end
      end
      bpep_pkg::S_INSERT: begin
        if (out_free) state_d = full_new ? bpep_pkg::S_IDLE : bpep_pkg::S_DATA;
      end
      bpep_pkg::S_DATA: begin
        if (out_free) state_d = full_new ? bpep_pkg::S_IDLE : bpep_pkg::S_GATHER;
      end
      bpep_pkg::S_EMPTY: begin
        if (out_free) state_d = bpep_pkg::S_IDLE;
      end
      default: state_d = bpep_pkg::S_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    in_ready_o = (state_q == bpep_pkg::S_IDLE);
  end

  // Datapath updates driven by the sequencer.
  always_comb begin
    code_d      = code_q;
    rem_d       = rem_q;
    prevent_d   = prevent_q;
    emitted_d   = emitted_q;
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    byte_d      = byte_q;
    zero_run_d  = zero_run_q;
    stored_d    = stored_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      bpep_pkg::S_IDLE: begin
        if (accept) begin
          code_d    = in_data_i.code_word;
          // A write while full is dropped entirely.
          rem_d     = full_q ? 6'd0 : n_clamped;
          prevent_d = prev_en_q && (n_clamped != bpep_pkg::NoPreventWidth);
          emitted_d = 1'b0;
        end
      end
      bpep_pkg::S_GATHER: begin
        rem_d = merge.rem;
        if (merge.byte_done) begin
          byte_d      = merge.bits;
          pend_bits_d = 8'd0;
          pend_cnt_d  = 3'd0;
        end else begin
          pend_bits_d = merge.bits;
          pend_cnt_d  = merge.count;
        end
      end
      bpep_pkg::S_INSERT, bpep_pkg::S_DATA: begin
        if (out_free) begin
          zero_run_d        = zero_run_new;
          stored_d          = stored_inc;
          full_d            = full_new;
          emitted_d         = 1'b1;
          out_valid_d       = 1'b1;
          out_d.byte_valid  = 1'b1;
          out_d.out_byte    = store_val;
          out_d.full_error  = full_new;
          if (state_q == bpep_pkg::S_INSERT) begin
            out_d.is_inserted = 1'b1;
            out_d.last        = full_new;
          end else begin
            // Last when the buffer fills or too few bits remain for another byte.
            out_d.is_inserted = 1'b0;
            out_d.last        = full_new || (rem_q < {2'b0, bpep_pkg::ByteBits});
          end
          // Filling the buffer drops the rest of the write.
          if (full_new) rem_d = 6'd0;
        end
      end
      bpep_pkg::S_EMPTY: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.byte_valid  = 1'b0;
          out_d.out_byte    = bpep_pkg::ZeroByte;
          out_d.is_inserted = 1'b0;
          out_d.full_error  = full_q;
          out_d.last        = 1'b1;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpep_pkg::S_IDLE;
      cap_q       <= bpep_pkg::CapacityReset;
      prev_en_q   <= bpep_pkg::PreventReset;
      rem_q       <= 6'd0;
      prevent_q   <= 1'b0;
      emitted_q   <= 1'b0;
      pend_bits_q <= 8'd0;
      pend_cnt_q  <= 3'd0;
      zero_run_q  <= 2'd0;
      stored_q    <= 21'd0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      prevent_q   <= prevent_d;
      emitted_q   <= emitted_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      zero_run_q  <= zero_run_d;
      stored_q    <= stored_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bpep_pkg::CfgCapacity: cap_q     <= cfg_data_i;
          bpep_pkg::CfgPrevent:  prev_en_q <= cfg_data_i[0];
          default:               cap_q     <= cap_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    byte_q <= byte_d;
    out_q  <= out_d;
  end

  // Output port drive.
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An inserted byte is 0x03 and ends a write only when the buffer filled.
  `BPEP_ASSERT_NOW(a_insert_form, clk_i, rst_ni, out_valid_o && out_data_o.is_inserted, out_data_o.byte_valid && (out_data_o.out_byte == bpep_pkg::EpbByte) && (!out_data_o.last || out_data_o.full_error), "inserted byte malformed")

  // An empty marker is always the final and only result of its write.
  `BPEP_ASSERT_NOW(a_empty_last, clk_i, rst_ni, out_valid_o && !out_data_o.byte_valid, out_data_o.last && (out_data_o.out_byte == bpep_pkg::ZeroByte) && !out_data_o.is_inserted, "empty result malformed")

  // The full flag is sticky.
  `BPEP_ASSERT_NEXT(a_full_sticky, clk_i, rst_ni, full_q, full_q, "full flag cleared")

endmodule

`default_nettype wire
